@@ rtl/tvc_pkg.sv @@
// ----------------------------------------------------------------------------
// tvc_pkg : shared types and constants of the timed valve channel controller
// Command codes, result codes, field widths and the control and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tvc_pkg;

   localparam int CHANNELS_DEF = 8;
   localparam int CHANNELS_MAX = 16;

   localparam int CMD_W  = 4;
   localparam int CH_FW  = 4;
   localparam int DUR_W  = 24;
   localparam int Q_W    = 17;
   localparam int TIME_W = 32;
   localparam int KIND_W = 2;
   localparam int EV_W   = 2;
   localparam int CONF_W = 16;
   localparam int MASK_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int PROD_W = 2 * Q_W;

   localparam logic [Q_W-1:0] FULL_Q = 17'd65536;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_OPEN_DEF  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_OPEN_TIME = 4'd2;
   localparam logic [CMD_W-1:0] CMD_CLOSE     = 4'd3;
   localparam logic [CMD_W-1:0] CMD_TOGGLE    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_CLOSE_ALL = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SET_AP    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SET_TIME  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_N2_TIME   = 4'd9;
   localparam logic [CMD_W-1:0] CMD_N2_DEF    = 4'd10;
   localparam logic [CMD_W-1:0] CMD_N2_CLOSE  = 4'd11;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POS    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_N2     = 2'd2;

   // events
   localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EV_W-1:0] EV_OPENED = 2'd1;
   localparam logic [EV_W-1:0] EV_CLOSED = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_FRAC = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_OPEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_N2_DEF    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_MASK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_MASK = 3'd5;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_TICK_INC,
      OP_CH_EVAL,
      OP_CH_MUL,
      OP_N2_LOAD,
      OP_CMD_EXEC,
      OP_CA_EXEC,
      OP_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_close_all;
      logic last_ch;
   } dp_status_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [CH_FW-1:0] channel;
      logic [DUR_W-1:0] duration_ms;
      logic [Q_W-1:0]   aperture;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CH_FW-1:0]  out_channel;
      logic [Q_W-1:0]    position;
      logic [DUR_W-1:0]  open_time_readback;
      logic              is_open;
      logic              nitrogen_on;
      logic [EV_W-1:0]   event_res;
      logic              ok;
      logic              last;
   } res_type;

endpackage

@@ rtl/tvc_req_if.sv @@
// ----------------------------------------------------------------------------
// tvc_req_if : command channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface tvc_req_if;
   logic                        valid;
   logic                        ready;
   logic [tvc_pkg::CMD_W-1:0]   cmd;
   logic [tvc_pkg::CH_FW-1:0]   channel;
   logic [tvc_pkg::DUR_W-1:0]   duration_ms;
   logic [tvc_pkg::Q_W-1:0]     aperture;

   modport source (output valid, cmd, channel, duration_ms, aperture, input ready);
   modport sink   (input valid, cmd, channel, duration_ms, aperture, output ready);
endinterface

@@ rtl/tvc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tvc_rsp_if : result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface tvc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tvc_pkg::KIND_W-1:0]  kind;
   logic [tvc_pkg::CH_FW-1:0]   out_channel;
   logic [tvc_pkg::Q_W-1:0]     position;
   logic [tvc_pkg::DUR_W-1:0]   open_time_readback;
   logic                        is_open;
   logic                        nitrogen_on;
   logic [tvc_pkg::EV_W-1:0]    event_res;
   logic                        ok;
   logic                        last;

   modport source (output valid, kind, out_channel, position, open_time_readback,
                   is_open, nitrogen_on, event_res, ok, last, input ready);
   modport sink   (input valid, kind, out_channel, position, open_time_readback,
                   is_open, nitrogen_on, event_res, ok, last, output ready);
endinterface

@@ rtl/timed_valve_channel_controller_core.sv @@
// ----------------------------------------------------------------------------
// timed_valve_channel_controller_core : multi-channel timed valve controller
// Millisecond tick counter, per-channel open timers with auto-close, Q1.16
// aperture output with confidence wiggle, and a timed nitrogen relay.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          carries
//  req_if    in         valid/ready        cmd, channel, duration_ms, aperture
//  rsp_if    out        valid/ready        the results of each transaction, last marked
//  csr_*     in         write enable only  register index and write data
//
// A tick is a serial channel walk, evaluate, multiply, present for each
// channel, and then the nitrogen result. A close all walks the channels
// with one status result each; any other command gives a single result.
// Reset is synchronous and active high; it restores all channel state and
// registers. A stalled result holds the walk; no new command transaction is
// taken until the last result of the current one has gone.
// ----------------------------------------------------------------------------
module timed_valve_channel_controller_core #(
   parameter int CHANNELS = tvc_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tvc_req_if.sink                         req_if,
   tvc_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [tvc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tvc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tvc_pkg::ctl_cmd_type    ctl;
   tvc_pkg::dp_status_type  status;
   tvc_pkg::req_type        req;
   tvc_pkg::res_type        res;

   // gather the command payload
   assign req.cmd         = req_if.cmd;
   assign req.channel     = req_if.channel;
   assign req.duration_ms = req_if.duration_ms;
   assign req.aperture    = req_if.aperture;

   tvc_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .ctl       (ctl)
   );

   tvc_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .status    (status),
      .req       (req),
      .res       (res),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // drive the result payload from the result register
   assign rsp_if.kind               = res.kind;
   assign rsp_if.out_channel        = res.out_channel;
   assign rsp_if.position           = res.position;
   assign rsp_if.open_time_readback = res.open_time_readback;
   assign rsp_if.is_open            = res.is_open;
   assign rsp_if.nitrogen_on        = res.nitrogen_on;
   assign rsp_if.event_res          = res.event_res;
   assign rsp_if.ok                 = res.ok;
   assign rsp_if.last               = res.last;

   // no command taken while a result is on offer
   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("command ready while a result is pending");

   // an accepted transaction blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("ready high right after an accepted transaction");

   // a position result is never the final one of a tick
   a_pos_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind == tvc_pkg::KIND_POS) |-> !rsp_if.last)
      else $error("position result marked last");

endmodule

@@ rtl/tvc_datapath.sv @@
// ----------------------------------------------------------------------------
// tvc_datapath : channel state, configuration and result register
// Holds the counter, per-channel timers and apertures, executes one operation
// per cycle as commanded by the controller, none while the controller waits.
// ----------------------------------------------------------------------------
module tvc_datapath #(
   parameter int CHANNELS = tvc_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tvc_pkg::ctl_cmd_type            ctl,
   output tvc_pkg::dp_status_type          status,
   input  tvc_pkg::req_type                req,
   output tvc_pkg::res_type                res,
   input  logic                            csr_we,
   input  logic [tvc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tvc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);
   localparam logic [tvc_pkg::CH_FW:0] CH_COUNT = (tvc_pkg::CH_FW + 1)'(CHANNELS);
   localparam int TW = tvc_pkg::TIME_W;
   localparam int QW = tvc_pkg::Q_W;

   // configuration
   logic [tvc_pkg::CONF_W-1:0] conf_time_ff;
   logic [QW-1:0]              conf_frac_ff;
   logic [tvc_pkg::DUR_W-1:0]  def_open_ff;
   logic [tvc_pkg::DUR_W-1:0]  n2_def_ff;
   logic [tvc_pkg::MASK_W-1:0] open_mask_ff;
   logic [tvc_pkg::MASK_W-1:0] close_mask_ff;

   // state
   logic [TW-1:0]              now_ff;
   logic [TW-1:0]              n2_close_ff;
   logic [TW-1:0]              close_ff  [CHANNELS];
   logic [TW-1:0]              last_ff   [CHANNELS];
   logic [QW-1:0]              maxap_ff  [CHANNELS];
   logic [tvc_pkg::DUR_W-1:0]  otime_ff  [CHANNELS];
   logic                       tset_ff   [CHANNELS];

   tvc_pkg::req_type           req_ff;
   logic [CH_W-1:0]            idx_ff;

   // multiplier operands and product
   logic [QW-1:0]              mul_a_ff;
   logic [QW-1:0]              mul_b_ff;
   logic [tvc_pkg::PROD_W-1:0] prod_ff;
   logic                       use_mul_ff;

   tvc_pkg::res_type           res_ff;

   // channel walk evaluation
   logic [TW-1:0]  ev_close, ev_last_eff;
   logic           ev_open, ev_closing, ev_inwin;
   logic [QW-1:0]  frac_clamped, ev_factor;
   logic [15:0]    omask16, cmask16;
   logic [tvc_pkg::CH_FW-1:0] idx4;

   // single command evaluation
   logic [CH_W-1:0]            cidx;
   logic                       good;
   logic [tvc_pkg::DUR_W-1:0]  chan_time;
   logic [TW-1:0]              tick_now;
   logic [tvc_pkg::PROD_W-1:0] rounded;
   logic                       exec_opens;
   logic [TW-1:0]              exec_nc;
   tvc_pkg::res_type           exec_res;

   assign omask16 = {8'd0, open_mask_ff};
   assign cmask16 = {8'd0, close_mask_ff};
   assign idx4    = tvc_pkg::CH_FW'(idx_ff);
   assign tick_now = now_ff + 32'd1;

   assign frac_clamped = (conf_frac_ff > tvc_pkg::FULL_Q) ? tvc_pkg::FULL_Q : conf_frac_ff;
   assign ev_close    = close_ff[idx_ff];
   assign ev_open     = now_ff < ev_close;
   assign ev_closing  = !ev_open && (ev_close != '0);
   assign ev_last_eff = ev_closing ? now_ff : last_ff[idx_ff];
   assign ev_inwin    = {1'b0, now_ff} <
                        ({1'b0, ev_last_eff} + {17'd0, conf_time_ff});
   assign ev_factor   = ev_open ? (tvc_pkg::FULL_Q - frac_clamped) : frac_clamped;

   assign cidx      = req_ff.channel[CH_W-1:0];
   assign good      = {1'b0, req_ff.channel} < CH_COUNT;
   assign chan_time = tset_ff[cidx] ? otime_ff[cidx] : def_open_ff;

   // open, open timed, or toggle of a closed channel
   assign exec_opens = (req_ff.cmd == tvc_pkg::CMD_OPEN_DEF) ||
                       (req_ff.cmd == tvc_pkg::CMD_OPEN_TIME) ||
                       ((req_ff.cmd == tvc_pkg::CMD_TOGGLE) && (close_ff[cidx] == '0));
   assign exec_nc    = now_ff + {8'd0, (req_ff.cmd == tvc_pkg::CMD_OPEN_TIME) ?
                                       req_ff.duration_ms : chan_time};

   assign rounded = prod_ff + tvc_pkg::PROD_W'(32768);

   always_comb begin
      res = res_ff;
      res.nitrogen_on = (n2_close_ff != '0);
      if (use_mul_ff) begin
         res.position = rounded[QW+15:16];
      end
   end

   // status result of a single command
   always_comb begin
      exec_res = '{kind: tvc_pkg::KIND_STATUS, out_channel: '0, position: '0,
                   open_time_readback: '0, is_open: 1'b0, nitrogen_on: 1'b0,
                   event_res: tvc_pkg::EV_NONE, ok: 1'b1, last: 1'b1};
      if (req_ff.cmd == tvc_pkg::CMD_N2_TIME || req_ff.cmd == tvc_pkg::CMD_N2_DEF ||
          req_ff.cmd == tvc_pkg::CMD_N2_CLOSE) begin
         exec_res.out_channel = '0;
      end else if (req_ff.cmd > tvc_pkg::CMD_N2_CLOSE || !good) begin
         exec_res.out_channel = req_ff.channel;
         exec_res.ok          = 1'b0;
      end else begin
         exec_res.out_channel = req_ff.channel;
         exec_res.is_open     = (close_ff[cidx] != '0);
         priority if (exec_opens) begin
            exec_res.is_open   = (exec_nc != '0);
            exec_res.event_res = omask16[req_ff.channel] ?
                                 tvc_pkg::EV_OPENED : tvc_pkg::EV_NONE;
         end else if (req_ff.cmd == tvc_pkg::CMD_CLOSE ||
                      req_ff.cmd == tvc_pkg::CMD_TOGGLE) begin
            exec_res.is_open   = 1'b0;
            exec_res.event_res = cmask16[req_ff.channel] ?
                                 tvc_pkg::EV_CLOSED : tvc_pkg::EV_NONE;
         end else if (req_ff.cmd == tvc_pkg::CMD_SET_AP) begin
            if (req_ff.aperture > tvc_pkg::FULL_Q) begin
               exec_res.ok = 1'b0;
            end
         end else if (req_ff.cmd == tvc_pkg::CMD_QUERY) begin
            exec_res.position           = maxap_ff[cidx];
            exec_res.open_time_readback = chan_time;
         end else begin
            exec_res.ok = 1'b1;
         end
      end
   end

   assign status.is_tick      = (req_ff.cmd == tvc_pkg::CMD_TICK);
   assign status.is_close_all = (req_ff.cmd == tvc_pkg::CMD_CLOSE_ALL);
   assign status.last_ch      = (idx_ff == LAST_IDX);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         conf_time_ff  <= 16'd1000;
         conf_frac_ff  <= 17'd1966;
         def_open_ff   <= 24'd1000;
         n2_def_ff     <= 24'd1000;
         open_mask_ff  <= 8'hFF;
         close_mask_ff <= 8'hFF;
      end else if (csr_we) begin
         unique case (csr_index)
            tvc_pkg::CSR_CONF_TIME:  conf_time_ff  <= csr_wdata[15:0];
            tvc_pkg::CSR_CONF_FRAC:  conf_frac_ff  <= csr_wdata[16:0];
            tvc_pkg::CSR_DEF_OPEN:   def_open_ff   <= csr_wdata;
            tvc_pkg::CSR_N2_DEF:     n2_def_ff     <= csr_wdata;
            tvc_pkg::CSR_OPEN_MASK:  open_mask_ff  <= csr_wdata[7:0];
            tvc_pkg::CSR_CLOSE_MASK: close_mask_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // multiplier stage
   always_ff @(posedge clock) begin
      if (ctl.op == tvc_pkg::OP_CH_MUL) begin
         prod_ff <= mul_a_ff * mul_b_ff;
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff      <= '0;
         n2_close_ff <= '0;
         idx_ff      <= '0;
         use_mul_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            close_ff[c] <= '0;
            last_ff[c]  <= '0;
            maxap_ff[c] <= tvc_pkg::FULL_Q;
            tset_ff[c]  <= 1'b0;
         end
      end else begin
         unique case (ctl.op)
            tvc_pkg::OP_CAPTURE: begin
               req_ff <= req;
               idx_ff <= '0;
            end
            tvc_pkg::OP_TICK_INC: begin
               now_ff <= tick_now;
               if (!(tick_now < n2_close_ff)) begin
                  n2_close_ff <= '0;
               end
               idx_ff <= '0;
            end
            tvc_pkg::OP_CH_EVAL: begin
               if (ev_closing) begin
                  close_ff[idx_ff] <= '0;
                  last_ff[idx_ff]  <= now_ff;
               end
               mul_a_ff   <= maxap_ff[idx_ff];
               mul_b_ff   <= ev_factor;
               use_mul_ff <= !ev_inwin;
               res_ff.kind        <= tvc_pkg::KIND_POS;
               res_ff.out_channel <= idx4;
               res_ff.position    <= ev_open ? maxap_ff[idx_ff] : '0;
               res_ff.open_time_readback <= '0;
               res_ff.is_open     <= ev_open;
               res_ff.nitrogen_on <= 1'b0;
               res_ff.event_res   <= (ev_closing && cmask16[idx4]) ?
                                     tvc_pkg::EV_CLOSED : tvc_pkg::EV_NONE;
               res_ff.ok          <= 1'b1;
               res_ff.last        <= 1'b0;
            end
            tvc_pkg::OP_N2_LOAD: begin
               use_mul_ff <= 1'b0;
               res_ff     <= '{kind: tvc_pkg::KIND_N2, out_channel: '0, position: '0,
                               open_time_readback: '0, is_open: 1'b0,
                               nitrogen_on: 1'b0, event_res: tvc_pkg::EV_NONE,
                               ok: 1'b1, last: 1'b1};
            end
            tvc_pkg::OP_CA_EXEC: begin
               close_ff[idx_ff] <= '0;
               last_ff[idx_ff]  <= now_ff;
               use_mul_ff <= 1'b0;
               res_ff     <= '{kind: tvc_pkg::KIND_STATUS, out_channel: idx4,
                               position: '0, open_time_readback: '0, is_open: 1'b0,
                               nitrogen_on: 1'b0,
                               event_res: cmask16[idx4] ? tvc_pkg::EV_CLOSED
                                                        : tvc_pkg::EV_NONE,
                               ok: 1'b1, last: (idx_ff == LAST_IDX)};
            end
            tvc_pkg::OP_CMD_EXEC: begin
               use_mul_ff <= 1'b0;
               res_ff     <= exec_res;
               if (req_ff.cmd == tvc_pkg::CMD_N2_TIME) begin
                  n2_close_ff <= now_ff + {8'd0, req_ff.duration_ms};
               end else if (req_ff.cmd == tvc_pkg::CMD_N2_DEF) begin
                  n2_close_ff <= now_ff + {8'd0, n2_def_ff};
               end else if (req_ff.cmd == tvc_pkg::CMD_N2_CLOSE) begin
                  n2_close_ff <= '0;
               end else if (!(req_ff.cmd > tvc_pkg::CMD_N2_CLOSE) && good) begin
                  priority if (exec_opens) begin
                     close_ff[cidx] <= exec_nc;
                     last_ff[cidx]  <= now_ff;
                  end else if (req_ff.cmd == tvc_pkg::CMD_CLOSE ||
                               req_ff.cmd == tvc_pkg::CMD_TOGGLE) begin
                     close_ff[cidx] <= '0;
                     last_ff[cidx]  <= now_ff;
                  end else if (req_ff.cmd == tvc_pkg::CMD_SET_AP) begin
                     if (req_ff.aperture <= tvc_pkg::FULL_Q) begin
                        maxap_ff[cidx] <= req_ff.aperture;
                     end
                  end else if (req_ff.cmd == tvc_pkg::CMD_SET_TIME) begin
                     otime_ff[cidx] <= req_ff.duration_ms;
                     tset_ff[cidx]  <= 1'b1;
                  end else begin
                  end
               end
            end
            tvc_pkg::OP_NEXT: begin
               idx_ff <= idx_ff + CH_W'(1);
            end
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/tvc_controller.sv @@
// ----------------------------------------------------------------------------
// tvc_controller : sequencing state machine
// Accepts one transaction, walks the channels or runs a single command and
// hands the results out one at a time.
// ----------------------------------------------------------------------------
module tvc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tvc_pkg::dp_status_type  status,
   output tvc_pkg::ctl_cmd_type    ctl
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DISPATCH = 10'b00_0000_0010,
      S_TICK     = 10'b00_0000_0100,
      S_EVAL     = 10'b00_0000_1000,
      S_MUL      = 10'b00_0001_0000,
      S_EMIT_CH  = 10'b00_0010_0000,
      S_N2       = 10'b00_0100_0000,
      S_EXEC     = 10'b00_1000_0000,
      S_CA_EXEC  = 10'b01_0000_0000,
      S_EMIT     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT_CH) || (state_ff == S_EMIT);

   always_comb begin
      state_in = state_ff;
      ctl.op   = tvc_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op   = tvc_pkg::OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.is_tick)      state_in = S_TICK;
            else if (status.is_close_all)     state_in = S_CA_EXEC;
            else                              state_in = S_EXEC;
         end
         S_TICK: begin
            ctl.op   = tvc_pkg::OP_TICK_INC;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            ctl.op   = tvc_pkg::OP_CH_EVAL;
            state_in = S_MUL;
         end
         S_MUL: begin
            ctl.op   = tvc_pkg::OP_CH_MUL;
            state_in = S_EMIT_CH;
         end
         S_EMIT_CH: begin
            if (rsp_ready) begin
               if (status.last_ch) begin
                  state_in = S_N2;
               end else begin
                  ctl.op   = tvc_pkg::OP_NEXT;
                  state_in = S_EVAL;
               end
            end
         end
         S_N2: begin
            ctl.op   = tvc_pkg::OP_N2_LOAD;
            state_in = S_EMIT;
         end
         S_EXEC: begin
            ctl.op   = tvc_pkg::OP_CMD_EXEC;
            state_in = S_EMIT;
         end
         S_CA_EXEC: begin
            ctl.op   = tvc_pkg::OP_CA_EXEC;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               // close all keeps walking until the last channel
               if (status.is_close_all && !status.last_ch) begin
                  ctl.op   = tvc_pkg::OP_NEXT;
                  state_in = S_CA_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ tb/tvc_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvc_scoreboard : result predictor and checker of the valve controller
// Watches the command, result and register ports, keeps its own copy of the
// timers, apertures and registers, predicts the results of every command and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module tvc_scoreboard import tvc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tvc_req_if                    req,
   tvc_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   logic [15:0]       conf_ms;
   logic [16:0]       conf_frac;
   logic [23:0]       def_open;
   logic [23:0]       n2_def;
   logic [7:0]        open_mask;
   logic [7:0]        close_mask;

   logic [31:0]       now_ms;
   logic [31:0]       n2_close;
   logic [31:0]       close_t    [CHANNELS];
   logic [31:0]       last_act   [CHANNELS];
   logic [16:0]       max_ap     [CHANNELS];
   logic [23:0]       open_t     [CHANNELS];
   logic              open_t_set [CHANNELS];

   res_type           expected_q [$];

   initial pending = 0;

   function automatic logic [16:0] qmul(input logic [16:0] a, input logic [31:0] b);
      logic [49:0] p;
      p = a * b + 50'd32768;
      return p[32:16];
   endfunction

   function automatic logic in_window(input int c);
      return {1'b0, now_ms} < ({1'b0, last_act[c]} + 33'(conf_ms));
   endfunction

   function automatic logic [1:0] open_valve(input int c, input logic [31:0] t);
      close_t[c]  = now_ms + t;
      last_act[c] = now_ms;
      return open_mask[c] ? EV_OPENED : EV_NONE;
   endfunction

   function automatic logic [1:0] shut_valve(input int c);
      close_t[c]  = 0;
      last_act[c] = now_ms;
      return close_mask[c] ? EV_CLOSED : EV_NONE;
   endfunction

   function automatic logic [23:0] valve_time(input int c);
      return open_t_set[c] ? open_t[c] : def_open;
   endfunction

   task automatic push_result(input logic [1:0] kind, input int c, input logic [16:0] pos,
                              input logic [23:0] rb, input logic isopen,
                              input logic [1:0] ev, input logic okb);
      res_type e;
      e.kind = kind;
      e.out_channel = c[3:0];
      e.position = pos;
      e.open_time_readback = rb;
      e.is_open = isopen;
      e.nitrogen_on = (n2_close != 0);
      e.event_res = ev;
      e.ok = okb;
      e.last = 1'b0;
      expected_q.push_back(e);
   endtask

   // work out the results of one accepted command transaction
   task automatic predict_results(input req_type r);
      logic [31:0] f;
      logic [16:0] p;
      logic [1:0]  ev;
      logic        inwin;
      logic        okb;
      int          c;
      c = int'(r.channel);
      ev = EV_NONE;
      okb = 1'b1;
      if (r.cmd == CMD_TICK) begin
         f = (conf_frac > FULL_Q) ? 32'(FULL_Q) : 32'(conf_frac);
         now_ms = now_ms + 1;
         if (!(now_ms < n2_close)) n2_close = 0;
         for (int k = 0; k < CHANNELS; k++) begin
            inwin = in_window(k);
            ev = EV_NONE;
            if (now_ms < close_t[k]) begin
               p = inwin ? max_ap[k] : qmul(max_ap[k], 32'd65536 - f);
            end else begin
               if (close_t[k] != 0) begin
                  ev = shut_valve(k);
                  inwin = in_window(k);
               end
               p = inwin ? 17'd0 : qmul(max_ap[k], f);
            end
            push_result(KIND_POS, k, p, 0, close_t[k] != 0, ev, 1'b1);
         end
         push_result(KIND_N2, 0, 0, 0, 1'b0, EV_NONE, 1'b1);
      end else if (r.cmd == CMD_CLOSE_ALL) begin
         for (int k = 0; k < CHANNELS; k++) begin
            ev = shut_valve(k);
            push_result(KIND_STATUS, k, 0, 0, 1'b0, ev, 1'b1);
         end
      end else if (r.cmd == CMD_N2_TIME || r.cmd == CMD_N2_DEF || r.cmd == CMD_N2_CLOSE) begin
         if (r.cmd == CMD_N2_TIME) n2_close = now_ms + 32'(r.duration_ms);
         else if (r.cmd == CMD_N2_DEF) n2_close = now_ms + 32'(n2_def);
         else n2_close = 0;
         push_result(KIND_STATUS, 0, 0, 0, 1'b0, EV_NONE, 1'b1);
      end else if (r.cmd > CMD_N2_CLOSE || c >= CHANNELS) begin
         push_result(KIND_STATUS, c, 0, 0, 1'b0, EV_NONE, 1'b0);
      end else begin
         p = 0;
         f = 0;
         case (r.cmd)
            CMD_OPEN_DEF: ev = open_valve(c, 32'(valve_time(c)));
            CMD_OPEN_TIME: ev = open_valve(c, 32'(r.duration_ms));
            CMD_CLOSE: ev = shut_valve(c);
            CMD_TOGGLE: begin
               ev = (close_t[c] == 0) ? open_valve(c, 32'(valve_time(c))) : shut_valve(c);
            end
            CMD_SET_AP: begin
               if (r.aperture <= FULL_Q) max_ap[c] = r.aperture;
               else okb = 1'b0;
            end
            CMD_SET_TIME: begin
               open_t[c] = r.duration_ms;
               open_t_set[c] = 1'b1;
            end
            default: begin
               p = max_ap[c];
               f = 32'(valve_time(c));
            end
         endcase
         push_result(KIND_STATUS, c, p, f[23:0], close_t[c] != 0, ev, okb);
      end
      expected_q[$].last = 1'b1;
   endtask

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      res_type e;
      req_type r;
      if (reset) begin
         conf_ms = 16'd1000;
         conf_frac = 17'd1966;
         def_open = 24'd1000;
         n2_def = 24'd1000;
         open_mask = 8'hFF;
         close_mask = 8'hFF;
         now_ms = 0;
         n2_close = 0;
         for (int k = 0; k < CHANNELS; k++) begin
            close_t[k] = 0;
            last_act[k] = 0;
            max_ap[k] = FULL_Q;
            open_t[k] = 0;
            open_t_set[k] = 1'b0;
         end
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CONF_TIME:  conf_ms = csr_wdata[15:0];
               CSR_CONF_FRAC:  conf_frac = csr_wdata[16:0];
               CSR_DEF_OPEN:   def_open = csr_wdata;
               CSR_N2_DEF:     n2_def = csr_wdata;
               CSR_OPEN_MASK:  open_mask = csr_wdata[7:0];
               CSR_CLOSE_MASK: close_mask = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result", 0, 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp.kind !== e.kind) report("kind", rsp.kind, e.kind);
               if (rsp.out_channel !== e.out_channel)
                  report("out_channel", rsp.out_channel, e.out_channel);
               if (rsp.position !== e.position) report("position", rsp.position, e.position);
               if (rsp.open_time_readback !== e.open_time_readback)
                  report("open_time_readback", rsp.open_time_readback, e.open_time_readback);
               if (rsp.is_open !== e.is_open) report("is_open", rsp.is_open, e.is_open);
               if (rsp.nitrogen_on !== e.nitrogen_on)
                  report("nitrogen_on", rsp.nitrogen_on, e.nitrogen_on);
               if (rsp.event_res !== e.event_res) report("event_res", rsp.event_res, e.event_res);
               if (rsp.ok !== e.ok) report("ok", rsp.ok, e.ok);
               if (rsp.last !== e.last) report("last", rsp.last, e.last);
            end
         end
         if (req.valid && req.ready) begin
            r.cmd = req.cmd;
            r.channel = req.channel;
            r.duration_ms = req.duration_ms;
            r.aperture = req.aperture;
            predict_results(r);
         end
      end
      pending = expected_q.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : testbench of the timed valve channel controller
// Drives a directed command sequence and then random commands through four
// register settings and four idling patterns; a scoreboard beside the block
// predicts and checks every result transaction.
// ----------------------------------------------------------------------------
module tb_top;
   import tvc_pkg::*;

   localparam int CHANNELS  = CHANNELS_DEF;
   localparam int WD_LIMIT  = 5000;   // cycles with no transaction on either channel
   localparam int SETTLE    = 40;     // longer than a full tick walk
   localparam int PER_PHASE = 108;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    quiet_cycles;

   tvc_req_if req_ch ();
   tvc_rsp_if rsp_ch ();

   timed_valve_channel_controller_core #(.CHANNELS(CHANNELS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tvc_scoreboard #(.CHANNELS(CHANNELS)) i_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // receiver: decide ready on each falling edge from the current stall rate
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: give up when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic req_type make_cmd(input logic [3:0] cmd, input logic [3:0] ch,
                                        input logic [23:0] dur, input logic [16:0] ap);
      req_type r;
      r.cmd = cmd;
      r.channel = ch;
      r.duration_ms = dur;
      r.aperture = ap;
      return r;
   endfunction

   // random command: ticks for almost half, mostly valid channels, short timers
   function automatic req_type random_cmd();
      req_type r;
      int k;
      k = $urandom_range(99);
      if (k < 45) r.cmd = CMD_TICK;
      else if (k < 96) r.cmd = 4'($urandom_range(CMD_OPEN_DEF, CMD_N2_CLOSE));
      else r.cmd = 4'($urandom_range(12, 15));
      r.channel = ($urandom_range(9) < 8) ? 4'($urandom_range(CHANNELS - 1))
                                           : 4'($urandom_range(15));
      r.duration_ms = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(40));
      case ($urandom_range(3))
         0: r.aperture = FULL_Q;
         1: r.aperture = 17'($urandom);
         default: r.aperture = 17'($urandom_range(65536));
      endcase
      return r;
   endfunction

   // hand one command over; called and returns at a falling edge
   task automatic send_cmd(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = r.cmd;
      req_ch.channel = r.channel;
      req_ch.duration_ms = r.duration_ms;
      req_ch.aperture = r.aperture;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // hold the sender until every expected result has arrived, then let the block settle
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all(input logic [15:0] ct, input logic [16:0] cf, input logic [23:0] dop,
                            input logic [23:0] nd, input logic [7:0] om, input logic [7:0] cm);
      write_reg(CSR_CONF_TIME, 24'(ct));
      write_reg(CSR_CONF_FRAC, 24'(cf));
      write_reg(CSR_DEF_OPEN, dop);
      write_reg(CSR_N2_DEF, nd);
      write_reg(CSR_OPEN_MASK, 24'(om));
      write_reg(CSR_CLOSE_MASK, 24'(cm));
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.channel = '0;
      req_ch.duration_ms = '0;
      req_ch.aperture = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      quiet_cycles = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every command, field extremes, rejections and nitrogen timing
      send_cmd(make_cmd(CMD_TICK, 0, 0, 0));
      send_cmd(make_cmd(CMD_SET_TIME, 2, 5, 0));
      send_cmd(make_cmd(CMD_QUERY, 2, 0, 0));
      send_cmd(make_cmd(CMD_QUERY, 3, 0, 0));
      send_cmd(make_cmd(CMD_OPEN_DEF, 2, 0, 0));
      send_cmd(make_cmd(CMD_OPEN_TIME, 1, 24'hFFFFFF, 17'h1FFFF));
      send_cmd(make_cmd(CMD_OPEN_TIME, 0, 0, 0));
      send_cmd(make_cmd(CMD_TOGGLE, 3, 0, 0));
      send_cmd(make_cmd(CMD_TOGGLE, 3, 0, 0));
      send_cmd(make_cmd(CMD_SET_AP, 1, 0, 0));
      send_cmd(make_cmd(CMD_SET_AP, 4, 0, FULL_Q));
      send_cmd(make_cmd(CMD_SET_AP, 5, 0, 17'd65537));
      send_cmd(make_cmd(CMD_SET_AP, 6, 0, 17'h1FFFF));
      send_cmd(make_cmd(CMD_CLOSE, 7, 0, 0));
      send_cmd(make_cmd(CMD_OPEN_DEF, 15, 24'hFFFFFF, 0));
      send_cmd(make_cmd(4'd12, 8, 0, 0));
      send_cmd(make_cmd(4'd15, 0, 0, 0));
      send_cmd(make_cmd(CMD_N2_TIME, 9, 3, 0));
      send_cmd(make_cmd(CMD_TICK, 0, 0, 0));
      send_cmd(make_cmd(CMD_N2_DEF, 0, 0, 0));
      send_cmd(make_cmd(CMD_N2_CLOSE, 0, 0, 0));
      send_cmd(make_cmd(CMD_CLOSE_ALL, 0, 0, 0));
      send_cmd(make_cmd(CMD_TICK, 0, 0, 0));

      // random phases, each with its own register setting and idling pattern
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: write_all(16'd0, 17'd0, 24'd0, 24'hFFFFFF, 8'h00, 8'hAA);
            1: write_all(16'hFFFF, 17'h1FFFF, 24'hFFFFFF, 24'd0, 8'hFF, 8'h00);
            2: write_all(16'd3, 17'($urandom), 24'd7, 24'd5, 8'($urandom), 8'($urandom));
            default: write_all(16'd0, FULL_Q, 24'd2, 24'd2, 8'h55, 8'hFF);
         endcase
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         for (int i = 0; i < PER_PHASE; i++) begin
            send_cmd(random_cmd());
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
